/* hdl/crrl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrl_pkg
// Shared constants, codes and types of the checksummed record ring log.
// ----------------------------------------------------------------------------
package crrl_pkg;

    localparam int NUM_RECORDS_DEF  = 64;
    localparam int RECORD_BYTES_DEF = 64;

    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 7;
    localparam int FLEN_W = 6;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int LEN_CAP = 62;

    localparam logic [FLEN_W-1:0] FRAME_LENGTH_RESET = 6'd38;
    localparam logic [BYTE_W-1:0] OCCUPIED_TAG       = 8'hC5;

    localparam logic REG_FRAME_LENGTH = 1'b0;

    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEEK     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TRUNCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_CHECKSUM = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_TAG   = 3'd4;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_COPY_PRE  = 10'b00_0000_0010,
        S_COPY      = 10'b00_0000_0100,
        S_RD_HDR0   = 10'b00_0000_1000,
        S_RD_HDR1   = 10'b00_0001_0000,
        S_RD_HDR2   = 10'b00_0010_0000,
        S_RD_REQ    = 10'b00_0100_0000,
        S_RD_CAP    = 10'b00_1000_0000,
        S_TRUNC     = 10'b01_0000_0000,
        S_EMIT      = 10'b10_0000_0000
    } t_state;

endpackage

/* hdl/crrl_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrl_in_if
// Command channel: one command item with its write byte and last flag.
// ----------------------------------------------------------------------------
interface crrl_in_if;
    logic                           valid;
    logic                           ready;
    logic [crrl_pkg::CMD_W-1:0]     command;
    logic [crrl_pkg::BYTE_W-1:0]    data_byte;
    logic                           last;

    modport source (output valid, command, data_byte, last, input ready);
    modport sink   (input valid, command, data_byte, last, output ready);
endinterface

/* hdl/crrl_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrl_out_if
// Result channel: one result item with payload byte, status and counts.
// ----------------------------------------------------------------------------
interface crrl_out_if;
    logic                           valid;
    logic                           ready;
    logic [crrl_pkg::BYTE_W-1:0]    data_out;
    logic                           last_out;
    logic [crrl_pkg::STAT_W-1:0]    status;
    logic [crrl_pkg::CNT_W-1:0]     records_to_read;
    logic [crrl_pkg::CNT_W-1:0]     records_to_delete;
    logic [crrl_pkg::CNT_W-1:0]     records_free;

    modport source (output valid, data_out, last_out, status, records_to_read,
                    records_to_delete, records_free, input ready);
    modport sink   (input valid, data_out, last_out, status, records_to_read,
                    records_to_delete, records_free, output ready);
endinterface

/* hdl/crrl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module crrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/crrl_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrl_seq
// Command sequencer: pointers, counts, staging, store sweeps and result item.
// ----------------------------------------------------------------------------
module crrl_seq #(
    parameter int NUM_RECORDS  = crrl_pkg::NUM_RECORDS_DEF,
    parameter int RECORD_BYTES = crrl_pkg::RECORD_BYTES_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [$clog2(RECORD_BYTES)-1:0]            i_len,
    crrl_in_if.sink                                    i_cmd,
    crrl_out_if.source                                 o_res,
    output logic                                       o_st_we,
    output logic [$clog2(NUM_RECORDS*RECORD_BYTES)-1:0] o_st_waddr,
    output logic [crrl_pkg::BYTE_W-1:0]                o_st_wdata,
    output logic                                       o_st_re,
    output logic [$clog2(NUM_RECORDS*RECORD_BYTES)-1:0] o_st_raddr,
    input  logic [crrl_pkg::BYTE_W-1:0]                i_st_rdata,
    output logic                                       o_sg_we,
    output logic [$clog2(RECORD_BYTES)-1:0]            o_sg_waddr,
    output logic [crrl_pkg::BYTE_W-1:0]                o_sg_wdata,
    output logic                                       o_sg_re,
    output logic [$clog2(RECORD_BYTES)-1:0]            o_sg_raddr,
    input  logic [crrl_pkg::BYTE_W-1:0]                i_sg_rdata
);

    localparam int BW = $clog2(RECORD_BYTES);
    localparam int PW = $clog2(NUM_RECORDS);
    localparam int CW = $clog2(NUM_RECORDS + 1);
    localparam int AW = $clog2(NUM_RECORDS * RECORD_BYTES);
    localparam int DW = crrl_pkg::BYTE_W;
    localparam int SW = crrl_pkg::STAT_W;
    localparam int NW = crrl_pkg::CNT_W;

    function automatic logic [AW-1:0] slot_base(input logic [PW-1:0] p);
        return AW'(p) * AW'(RECORD_BYTES);
    endfunction

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == PW'(NUM_RECORDS - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
        return (a == AW'(NUM_RECORDS * RECORD_BYTES - 1)) ? '0 : a + AW'(1);
    endfunction

    crrl_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp, r_dp, n_dp;
    logic [CW-1:0]    r_ctr, n_ctr, r_ctd, n_ctd, r_cf, n_cf;
    logic [BW-1:0]    r_bidx, n_bidx, r_idx, n_idx;
    logic [DW-1:0]    r_sum, n_sum, r_chk, n_chk, r_tag, n_tag;
    logic [AW-1:0]    r_addr, n_addr;
    logic [SW-1:0]    r_status, n_status;

    logic             r_out_valid, n_out_valid;
    logic [DW-1:0]    r_out_data, n_out_data;
    logic             r_out_last, n_out_last;
    logic [SW-1:0]    r_out_status, n_out_status;
    logic [NW-1:0]    r_out_ctr, n_out_ctr, r_out_ctd, n_out_ctd, r_out_cf, n_out_cf;

    logic             accept;
    logic             out_free;
    logic [BW-1:0]    neff;

    assign i_cmd.ready = (r_state == crrl_pkg::S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign neff        = (r_bidx < i_len) ? r_bidx : i_len;

    always_comb begin
        logic          load;
        logic [DW-1:0] ld_data;
        logic          ld_last;
        logic [SW-1:0] ld_status;
        logic [DW-1:0] sum_rd;
        logic          fin;

        n_state  = r_state;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_dp     = r_dp;
        n_ctr    = r_ctr;
        n_ctd    = r_ctd;
        n_cf     = r_cf;
        n_bidx   = r_bidx;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_chk    = r_chk;
        n_tag    = r_tag;
        n_addr   = r_addr;
        n_status = r_status;

        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        n_out_ctr    = r_out_ctr;
        n_out_ctd    = r_out_ctd;
        n_out_cf     = r_out_cf;

        load      = 1'b0;
        ld_data   = '0;
        ld_last   = 1'b1;
        ld_status = crrl_pkg::ST_OK;
        sum_rd    = r_sum + i_st_rdata;
        fin       = (r_idx == i_len - BW'(1));

        o_st_we    = 1'b0;
        o_st_waddr = r_addr;
        o_st_wdata = '0;
        o_st_re    = 1'b0;
        o_st_raddr = r_addr;
        o_sg_we    = 1'b0;
        o_sg_waddr = r_bidx;
        o_sg_wdata = i_cmd.data_byte;
        o_sg_re    = 1'b0;
        o_sg_raddr = r_idx;

        unique case (r_state)
            crrl_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = crrl_pkg::ST_OK;
                    unique case (i_cmd.command)
                        crrl_pkg::CMD_WRITE: begin
                            if (r_bidx < i_len) begin
                                o_sg_we = 1'b1;
                                n_bidx  = r_bidx + BW'(1);
                            end
                            if (i_cmd.last) begin
                                if (r_ctd == CW'(NUM_RECORDS)) begin
                                    n_status = crrl_pkg::ST_FULL;
                                    n_bidx   = '0;
                                    n_state  = crrl_pkg::S_EMIT;
                                end else begin
                                    n_addr  = slot_base(r_wp);
                                    n_wp    = next_slot(r_wp);
                                    n_ctr   = r_ctr + CW'(1);
                                    n_ctd   = r_ctd + CW'(1);
                                    n_cf    = r_cf - CW'(1);
                                    n_state = crrl_pkg::S_COPY_PRE;
                                end
                            end
                        end
                        crrl_pkg::CMD_READ: begin
                            if (r_ctr == '0) begin
                                n_status = crrl_pkg::ST_EMPTY;
                                n_state  = crrl_pkg::S_EMIT;
                            end else begin
                                n_addr  = slot_base(r_rp);
                                n_rp    = next_slot(r_rp);
                                n_ctr   = r_ctr - CW'(1);
                                n_state = crrl_pkg::S_RD_HDR0;
                            end
                        end
                        crrl_pkg::CMD_SEEK: begin
                            n_rp    = r_dp;
                            n_state = crrl_pkg::S_EMIT;
                        end
                        crrl_pkg::CMD_TRUNCATE: begin
                            if (r_ctd > r_ctr) begin
                                n_addr  = slot_base(r_dp);
                                n_idx   = '0;
                                n_state = crrl_pkg::S_TRUNC;
                            end else begin
                                n_state = crrl_pkg::S_EMIT;
                            end
                        end
                        default: begin
                            n_state = crrl_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            crrl_pkg::S_COPY_PRE: begin
                o_sg_re    = 1'b1;
                o_sg_raddr = '0;
                n_idx      = '0;
                n_sum      = '0;
                n_state    = crrl_pkg::S_COPY;
            end
            crrl_pkg::S_COPY: begin
                o_st_we    = 1'b1;
                o_st_waddr = r_addr;
                if (r_idx < neff) begin
                    o_st_wdata = i_sg_rdata;
                    n_sum      = r_sum + i_sg_rdata;
                end else if (r_idx == i_len) begin
                    o_st_wdata = ~r_sum;
                end else if (r_idx == BW'(RECORD_BYTES - 1)) begin
                    o_st_wdata = crrl_pkg::OCCUPIED_TAG;
                end else begin
                    o_st_wdata = '0;
                end
                o_sg_re = 1'b1;
                n_addr  = r_addr + AW'(1);
                if (r_idx == BW'(RECORD_BYTES - 1)) begin
                    o_sg_raddr = '0;
                    n_idx      = '0;
                    n_bidx     = '0;
                    n_state    = crrl_pkg::S_EMIT;
                end else begin
                    o_sg_raddr = r_idx + BW'(1);
                    n_idx      = r_idx + BW'(1);
                end
            end
            crrl_pkg::S_RD_HDR0: begin
                o_st_re    = 1'b1;
                o_st_raddr = r_addr + AW'(i_len);
                n_state    = crrl_pkg::S_RD_HDR1;
            end
            crrl_pkg::S_RD_HDR1: begin
                o_st_re    = 1'b1;
                o_st_raddr = r_addr + AW'(RECORD_BYTES - 1);
                n_chk      = i_st_rdata;
                n_state    = crrl_pkg::S_RD_HDR2;
            end
            crrl_pkg::S_RD_HDR2: begin
                n_tag   = i_st_rdata;
                n_idx   = '0;
                n_sum   = '0;
                n_state = crrl_pkg::S_RD_REQ;
            end
            crrl_pkg::S_RD_REQ: begin
                if (out_free) begin
                    o_st_re    = 1'b1;
                    o_st_raddr = r_addr + AW'(r_idx);
                    n_state    = crrl_pkg::S_RD_CAP;
                end
            end
            crrl_pkg::S_RD_CAP: begin
                load    = 1'b1;
                ld_data = i_st_rdata;
                ld_last = fin;
                if (!fin) begin
                    ld_status = crrl_pkg::ST_OK;
                end else if (~sum_rd != r_chk) begin
                    ld_status = crrl_pkg::ST_CHECKSUM;
                end else if (r_tag != crrl_pkg::OCCUPIED_TAG) begin
                    ld_status = crrl_pkg::ST_NO_TAG;
                end else begin
                    ld_status = crrl_pkg::ST_OK;
                end
                n_sum   = sum_rd;
                n_idx   = r_idx + BW'(1);
                n_state = fin ? crrl_pkg::S_IDLE : crrl_pkg::S_RD_REQ;
            end
            crrl_pkg::S_TRUNC: begin
                o_st_we    = 1'b1;
                o_st_waddr = r_addr;
                o_st_wdata = '0;
                n_addr     = next_addr(r_addr);
                if (r_idx == BW'(RECORD_BYTES - 1)) begin
                    n_idx = '0;
                    n_cf  = r_cf + CW'(1);
                    n_ctd = r_ctd - CW'(1);
                    n_dp  = next_slot(r_dp);
                    if ((r_ctd - CW'(1)) <= r_ctr) begin
                        n_state = crrl_pkg::S_EMIT;
                    end
                end else begin
                    n_idx = r_idx + BW'(1);
                end
            end
            crrl_pkg::S_EMIT: begin
                if (out_free) begin
                    load      = 1'b1;
                    ld_status = r_status;
                    n_state   = crrl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crrl_pkg::S_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid  = 1'b1;
            n_out_data   = ld_data;
            n_out_last   = ld_last;
            n_out_status = ld_status;
            n_out_ctr    = NW'(r_ctr);
            n_out_ctd    = NW'(r_ctd);
            n_out_cf     = NW'(r_cf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crrl_pkg::S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_dp        <= '0;
            r_ctr       <= '0;
            r_ctd       <= '0;
            r_cf        <= CW'(NUM_RECORDS);
            r_bidx      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_dp        <= n_dp;
            r_ctr       <= n_ctr;
            r_ctd       <= n_ctd;
            r_cf        <= n_cf;
            r_bidx      <= n_bidx;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum        <= n_sum;
        r_chk        <= n_chk;
        r_tag        <= n_tag;
        r_addr       <= n_addr;
        r_status     <= n_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_ctr    <= n_out_ctr;
        r_out_ctd    <= n_out_ctd;
        r_out_cf     <= n_out_cf;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.data_out          = r_out_data;
    assign o_res.last_out          = r_out_last;
    assign o_res.status            = r_out_status;
    assign o_res.records_to_read   = r_out_ctr;
    assign o_res.records_to_delete = r_out_ctd;
    assign o_res.records_free      = r_out_cf;

endmodule

/* hdl/checksummed_record_ring_log.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_record_ring_log
// Ring of checksummed, tagged records in an internal byte store.
// ----------------------------------------------------------------------------
// A write byte that is not the last of its record leaves the log idle and
// ready, so a frame streams in at one byte per cycle into a staging buffer.
// Unless the log is full, the last byte commits the frame by copying the
// whole slot of RECORD_BYTES bytes through the store's single write port
// before the result item is offered. A read fetches the checksum and tag
// bytes first and then streams the payload, reading each byte only after the
// previous one was captured and the result register is free. Truncate clears
// RECORD_BYTES bytes per freed record, one byte a cycle. Seek, status and a
// full or empty outcome go straight to the result item. The store needs no
// clearing after reset. The effective frame length is frame_length limited
// to 1 .. min(RECORD_BYTES-2, 62); change it only while the log is idle.
module checksummed_record_ring_log #(
    parameter int NUM_RECORDS  = crrl_pkg::NUM_RECORDS_DEF,
    parameter int RECORD_BYTES = crrl_pkg::RECORD_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crrl_pkg::APB_AW-1:0]    paddr,
    input  logic [crrl_pkg::APB_DW-1:0]    pwdata,
    output logic [crrl_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    crrl_in_if.sink                        i_cmd,
    crrl_out_if.source                     o_res
);

    localparam int BW   = $clog2(RECORD_BYTES);
    localparam int AW   = $clog2(NUM_RECORDS * RECORD_BYTES);
    localparam int DW   = crrl_pkg::BYTE_W;
    localparam int FW   = crrl_pkg::FLEN_W;
    localparam int LMAX = (RECORD_BYTES - 2 < crrl_pkg::LEN_CAP) ?
                          RECORD_BYTES - 2 : crrl_pkg::LEN_CAP;

    logic [FW-1:0] r_frame_length;
    logic [BW-1:0] len;
    logic          reg_sel;

    logic          st_we, st_re, sg_we, sg_re;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [BW-1:0] sg_waddr, sg_raddr;
    logic [DW-1:0] st_wdata, st_rdata, sg_wdata, sg_rdata;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == crrl_pkg::REG_FRAME_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= crrl_pkg::FRAME_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_frame_length <= pwdata[FW-1:0];
        end
    end

    assign prdata = reg_sel ? {{(crrl_pkg::APB_DW-FW){1'b0}}, r_frame_length} : '0;

    always_comb begin
        if (r_frame_length == '0) begin
            len = BW'(1);
        end else if (int'(r_frame_length) > LMAX) begin
            len = BW'(LMAX);
        end else begin
            len = BW'(r_frame_length);
        end
    end

    crrl_seq #(
        .NUM_RECORDS  (NUM_RECORDS),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_len      (len),
        .i_cmd      (i_cmd),
        .o_res      (o_res),
        .o_st_we    (st_we),
        .o_st_waddr (st_waddr),
        .o_st_wdata (st_wdata),
        .o_st_re    (st_re),
        .o_st_raddr (st_raddr),
        .i_st_rdata (st_rdata),
        .o_sg_we    (sg_we),
        .o_sg_waddr (sg_waddr),
        .o_sg_wdata (sg_wdata),
        .o_sg_re    (sg_re),
        .o_sg_raddr (sg_raddr),
        .i_sg_rdata (sg_rdata)
    );

    crrl_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_RECORDS * RECORD_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    crrl_ram #(
        .WIDTH (DW),
        .DEPTH (RECORD_BYTES)
    ) u_stage (
        .i_clk   (i_clk),
        .i_we    (sg_we),
        .i_waddr (sg_waddr),
        .i_wdata (sg_wdata),
        .i_re    (sg_re),
        .i_raddr (sg_raddr),
        .o_rdata (sg_rdata)
    );

endmodule

/* hdl/crrl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrl_checker
// Port-level checks on the result channel of the record ring log.
// ----------------------------------------------------------------------------
module crrl_checker #(
    parameter int NUM_RECORDS = crrl_pkg::NUM_RECORDS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [crrl_pkg::BYTE_W-1:0]   i_data_out,
    input logic                          i_last_out,
    input logic [crrl_pkg::STAT_W-1:0]   i_status,
    input logic [crrl_pkg::CNT_W-1:0]    i_to_read,
    input logic [crrl_pkg::CNT_W-1:0]    i_to_delete,
    input logic [crrl_pkg::CNT_W-1:0]    i_free
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result item withdrawn while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_data_out) && $stable(i_status)
                                && $stable(i_last_out))
        else $error("result item changed while stalled");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last_out |-> i_status == crrl_pkg::ST_OK)
        else $error("status reported before the final item");

    a_read_within_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (NUM_RECORDS < 128) |-> i_to_read <= i_to_delete)
        else $error("more records to read than to delete");

    a_slots_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> crrl_pkg::CNT_W'(i_to_delete + i_free)
                    == crrl_pkg::CNT_W'(NUM_RECORDS))
        else $error("occupied and free slots do not add up");

endmodule

bind checksummed_record_ring_log crrl_checker #(
    .NUM_RECORDS (NUM_RECORDS)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_data_out  (o_res.data_out),
    .i_last_out  (o_res.last_out),
    .i_status    (o_res.status),
    .i_to_read   (o_res.records_to_read),
    .i_to_delete (o_res.records_to_delete),
    .i_free      (o_res.records_free)
);
